// ===== design/hmbf_pkg.sv =====
// Shared constants, types and the header field name table for the HTTP message framer.
`default_nettype none

package hmbf_pkg;

  // Width of the declared length and of the body byte counter.
  localparam int LENGTH_BITS = 32;

  localparam int NAME_LEN = 14;
  localparam int NAME_POS_BITS = $clog2(NAME_LEN);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_C     = 8'h43;

  // Number parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } num_phase_t;

  // Characters of "Content-Length" by position.
  function automatic logic [7:0] name_char(input logic [NAME_POS_BITS-1:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/http_message_boundary_framer.sv =====
// Top level of the HTTP message framer: byte input register, framing logic, result register.
//
//   channel | signals                                              | direction
//   input   | in_valid, in_ready, data_byte                        | into block
//   output  | out_valid, out_ready, byte_out, in_header,           | out of block
//           | header_end, chunked, last                            |
//
// One byte per clock unless the output stalls; bytes pass the input then the result register.
// The framing state is updated in the single cycle in which a byte moves from the input
// register to the result register.
// Reset (rst, synchronous) empties both registers and returns the framing state to the
// start of a message.
// A stalled output holds its beat; an empty input register still takes one more byte.
`default_nettype none

module http_message_boundary_framer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      byte_out,
  output logic            in_header,
  output logic            header_end,
  output logic            chunked,
  output logic            last
);

  localparam int L = hmbf_pkg::LENGTH_BITS;
  localparam int PB = hmbf_pkg::NAME_POS_BITS;
  localparam logic [L-1:0] LEN_SIGN = {1'b1, {(L-1){1'b0}}};
  localparam logic [L-1:0] LEN_MAXP = {1'b0, {(L-1){1'b1}}};
  localparam logic [L-1:0] LEN_ALL1 = {L{1'b1}};

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_move;

  // Framing state.
  logic                 header_done, header_done_next;
  logic                 chunked_mode, chunked_mode_next;
  logic [L-1:0]         remaining_count, remaining_count_next;
  logic [31:0]          recent_bytes, recent_bytes_next;
  logic [2:0]           bytes_seen, bytes_seen_next;
  logic                 line_fresh, line_fresh_next;
  logic [PB-1:0]        name_match_pos, name_match_pos_next;
  logic                 name_found, name_found_next;
  logic                 colon_seen, colon_seen_next;
  hmbf_pkg::num_phase_t number_phase, number_phase_next;
  logic                 number_negative, number_negative_next;
  logic [L-1:0]         number_value, number_value_next;

  // Line state as seen by this byte (cleared when a new line starts).
  logic [PB-1:0]        pos_e;
  logic                 found_e, colon_e, neg_e;
  hmbf_pkg::num_phase_t phase_e;
  logic [L-1:0]         val_e;

  logic [7:0]   b, p1, p2, p3, p4;
  logic         is_digit, is_blank, is_sign;
  logic [L+3:0] val_x10;
  logic [L-1:0] signed_len;
  logic [L-1:0] rc_dec;
  logic         hdr_end, is_last;

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
    end
  end

  always_comb begin
    b  = s1_byte;
    p1 = recent_bytes[7:0];
    p2 = recent_bytes[15:8];
    p3 = recent_bytes[23:16];
    p4 = recent_bytes[31:24];

    is_digit = (b >= hmbf_pkg::CH_ZERO) && (b <= hmbf_pkg::CH_NINE);
    is_blank = (b == hmbf_pkg::CH_SPACE) || (b == hmbf_pkg::CH_TAB) ||
               (b == hmbf_pkg::CH_LF) || (b == hmbf_pkg::CH_VT) ||
               (b == hmbf_pkg::CH_FF) || (b == hmbf_pkg::CH_CR);
    is_sign  = (b == hmbf_pkg::CH_PLUS) || (b == hmbf_pkg::CH_MINUS);

    pos_e   = line_fresh ? '0 : name_match_pos;
    found_e = line_fresh ? 1'b0 : name_found;
    colon_e = line_fresh ? 1'b0 : colon_seen;
    neg_e   = line_fresh ? 1'b0 : number_negative;
    phase_e = line_fresh ? hmbf_pkg::PH_SKIP : number_phase;
    val_e   = line_fresh ? '0 : number_value;

    // Decimal accumulate: value * 10 + digit, clipped at the magnitude of the most
    // negative length.
    val_x10 = ({4'b0, val_e} << 3) + ({4'b0, val_e} << 1) +
              {{L{1'b0}}, (b[3:0])};
    signed_len = neg_e ? (~val_e + {{(L-1){1'b0}}, 1'b1})
                       : ((val_e > LEN_MAXP) ? LEN_MAXP : val_e);
    rc_dec = remaining_count - {{(L-1){1'b0}}, 1'b1};

    header_done_next     = header_done;
    chunked_mode_next    = chunked_mode;
    remaining_count_next = remaining_count;
    line_fresh_next      = line_fresh;
    name_match_pos_next  = name_match_pos;
    name_found_next      = name_found;
    colon_seen_next      = colon_seen;
    number_phase_next    = number_phase;
    number_negative_next = number_negative;
    number_value_next    = number_value;
    hdr_end = 1'b0;
    is_last = 1'b0;

    if (!header_done) begin
      name_match_pos_next  = pos_e;
      name_found_next      = found_e;
      colon_seen_next      = colon_e;
      number_phase_next    = phase_e;
      number_negative_next = neg_e;
      number_value_next    = val_e;

      if ((b == hmbf_pkg::CH_CR) && found_e && colon_e) begin
        remaining_count_next = signed_len;
      end

      if (!found_e) begin
        if (b == hmbf_pkg::name_char(pos_e)) begin
          name_match_pos_next = pos_e + 1'b1;
          if (pos_e == PB'(hmbf_pkg::NAME_LEN - 1)) begin
            name_found_next = 1'b1;
          end
        end else begin
          name_match_pos_next = (b == hmbf_pkg::CH_C) ? PB'(1) : '0;
        end
      end

      if (colon_e) begin
        if (phase_e == hmbf_pkg::PH_SKIP && is_sign) begin
          number_negative_next = (b == hmbf_pkg::CH_MINUS);
          number_phase_next    = hmbf_pkg::PH_DIGITS;
        end else if ((phase_e == hmbf_pkg::PH_SKIP && !is_blank) ||
                     phase_e == hmbf_pkg::PH_DIGITS) begin
          if (is_digit) begin
            number_phase_next = hmbf_pkg::PH_DIGITS;
            number_value_next = (val_x10 > {4'b0, LEN_SIGN}) ? LEN_SIGN : val_x10[L-1:0];
          end else begin
            number_phase_next = hmbf_pkg::PH_DONE;
          end
        end
      end else if (b == hmbf_pkg::CH_COLON) begin
        colon_seen_next = 1'b1;
      end

      line_fresh_next = (b == hmbf_pkg::CH_LF);

      if ((bytes_seen >= 3'd3) && (b == hmbf_pkg::CH_LF) && (p1 == hmbf_pkg::CH_CR) &&
          (p2 == hmbf_pkg::CH_LF) && (p3 == hmbf_pkg::CH_CR)) begin
        hdr_end          = 1'b1;
        header_done_next = 1'b1;
        if (remaining_count_next[L-1]) begin
          chunked_mode_next = 1'b1;
        end else if (remaining_count_next == '0) begin
          is_last = 1'b1;
        end
      end
    end else if (chunked_mode) begin
      is_last = (bytes_seen >= 3'd4) && (b == hmbf_pkg::CH_LF) &&
                (p1 == hmbf_pkg::CH_CR) && (p2 == hmbf_pkg::CH_LF) &&
                (p3 == hmbf_pkg::CH_CR) && (p4 == hmbf_pkg::CH_ZERO);
    end else begin
      remaining_count_next = rc_dec;
      is_last = (rc_dec == '0);
    end

    recent_bytes_next = {recent_bytes[23:0], b};
    bytes_seen_next   = (bytes_seen < 3'd4) ? bytes_seen + 3'd1 : bytes_seen;
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_move && is_last)) begin
      header_done     <= 1'b0;
      chunked_mode    <= 1'b0;
      remaining_count <= LEN_ALL1;
      recent_bytes    <= '0;
      bytes_seen      <= '0;
      line_fresh      <= 1'b1;
      name_match_pos  <= '0;
      name_found      <= 1'b0;
      colon_seen      <= 1'b0;
      number_phase    <= hmbf_pkg::PH_SKIP;
      number_negative <= 1'b0;
      number_value    <= '0;
    end else if (s1_move) begin
      header_done     <= header_done_next;
      chunked_mode    <= chunked_mode_next;
      remaining_count <= remaining_count_next;
      recent_bytes    <= recent_bytes_next;
      bytes_seen      <= bytes_seen_next;
      line_fresh      <= line_fresh_next;
      name_match_pos  <= name_match_pos_next;
      name_found      <= name_found_next;
      colon_seen      <= colon_seen_next;
      number_phase    <= number_phase_next;
      number_negative <= number_negative_next;
      number_value    <= number_value_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      byte_out   <= b;
      in_header  <= !header_done;
      header_end <= hdr_end;
      chunked    <= chunked_mode_next;
      last       <= is_last;
    end
  end

endmodule

`default_nettype wire

// ===== design/hmbf_checker.sv =====
// Port-level checker for the HTTP message framer, with its bind to the top level.
`default_nettype none

module hmbf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] byte_out,
  input wire logic       in_header,
  input wire logic       header_end,
  input wire logic       chunked,
  input wire logic       last
);

  // A beat waiting on the output holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(last) &&
                                $stable(in_header) && $stable(header_end))
    else $error("output beat changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // The header ends on a line feed that is still part of the header.
  a_hdr_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_end |-> in_header && (byte_out == hmbf_pkg::CH_LF))
    else $error("header end on wrong byte");

  // A chunked body can only end on the line feed of the closing blank line.
  a_chunk_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && chunked && !in_header |-> byte_out == hmbf_pkg::CH_LF)
    else $error("chunked message ended on wrong byte");

endmodule

bind http_message_boundary_framer hmbf_checker u_hmbf_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .byte_out   (byte_out),
  .in_header  (in_header),
  .header_end (header_end),
  .chunked    (chunked),
  .last       (last)
);

`default_nettype wire
